### design/beam_fixed_end_load_accumulator_defines.svh
// assertion macros for the beam fixed-end load accumulator
// used by the top level only; expects clk and rst in scope
`ifndef BEAM_FIXED_END_LOAD_ACCUMULATOR_DEFINES_SVH
`define BEAM_FIXED_END_LOAD_ACCUMULATOR_DEFINES_SVH

// implication checked in the next cycle, off during reset
`define BFELA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, off during reset
`define BFELA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// checked through reset as well
`define BFELA_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bfela_pkg.sv
// shared types, codes and the micro-op table of the load accumulator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bfela_pkg;

  localparam int DW        = 32;   // data width of values and accumulators
  localparam int PW        = 20;   // width of position terms
  localparam int SHIFT     = 16;   // fraction bits of every rounded product
  localparam int NUM_ACC   = 10;

  localparam logic signed [DW-1:0] Q_ONE      = 32'sd65536;
  localparam logic signed [DW-1:0] Q_HALF     = 32'sd32768;
  localparam logic signed [DW-1:0] Q_EIGHTH   = 32'sd8192;
  localparam logic signed [DW-1:0] DIV3_MAGIC = 32'sd1431655766;

  // configuration register indexes
  localparam logic [1:0] CFG_LENGTH = 2'd0;
  localparam logic [1:0] CFG_REL_Z  = 2'd1;
  localparam logic [1:0] CFG_REL_Y  = 2'd2;

  // load kinds
  localparam logic [1:0] KIND_UNIFORM = 2'd0;
  localparam logic [1:0] KIND_PARTIAL = 2'd1;
  localparam logic [1:0] KIND_POINT   = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // release codes
  localparam logic [1:0] REL_NONE = 2'd0;
  localparam logic [1:0] REL_I    = 2'd1;
  localparam logic [1:0] REL_J    = 2'd2;

  // result status
  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // multiplier modes
  localparam logic MODE_ROUND = 1'b0;
  localparam logic MODE_DIV12 = 1'b1;

  // operand sources
  localparam logic [4:0] S_CY = 5'd0,  S_CZ = 5'd1,  S_CA = 5'd2,  S_F = 5'd3;
  localparam logic [4:0] S_L = 5'd4,   S_G = 5'd5,   S_C = 5'd6,   S_OC = 5'd7;
  localparam logic [4:0] S_K3A = 5'd8, S_K3B = 5'd9, S_ONE = 5'd10, S_HALF = 5'd11;
  localparam logic [4:0] S_EIGHTH = 5'd12, S_WY = 5'd13, S_WZ = 5'd14, S_WA = 5'd15;
  localparam logic [4:0] S_LG = 5'd16, S_P = 5'd17,  S_SY = 5'd18, S_SZ = 5'd19;
  localparam logic [4:0] S_G2 = 5'd20, S_T = 5'd21,  S_KI = 5'd22, S_KJ = 5'd23;
  localparam logic [4:0] S_LY = 5'd24, S_LZ = 5'd25, S_TY = 5'd26, S_TZ = 5'd27;
  localparam int NUM_SRC = 32;

  // destinations
  localparam logic [4:0] D_NONE = 5'd0, D_WY = 5'd1, D_WZ = 5'd2, D_WA = 5'd3;
  localparam logic [4:0] D_LG = 5'd4, D_P = 5'd5, D_SY = 5'd6, D_SZ = 5'd7;
  localparam logic [4:0] D_G2 = 5'd8, D_T = 5'd9, D_KI = 5'd10, D_KJ = 5'd11;
  localparam logic [4:0] D_LY = 5'd12, D_LZ = 5'd13, D_TY = 5'd14, D_TZ = 5'd15;
  localparam logic [4:0] D_RA0 = 5'd16, D_RA1 = 5'd17, D_RA2 = 5'd18, D_RA3 = 5'd19;
  localparam logic [4:0] D_RA4 = 5'd20, D_FE0 = 5'd21, D_FE1 = 5'd22, D_FE2 = 5'd23;
  localparam logic [4:0] D_FE3 = 5'd24, D_FE4 = 5'd25;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic       mode;
    logic [4:0] dest;
    logic       accum;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       clear_acc;
    logic       set_status;
    logic [1:0] status_code;
    logic       issue;
    logic       wr;
    logic       load_out;
    uop_t       uop;
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic [1:0] kind;
    logic       point_oor;
    logic [1:0] rz;
    logic [1:0] ry;
  } stat_t;

  function automatic uop_t mk(input logic [4:0] a, input logic [4:0] b, input logic m,
                              input logic [4:0] d, input logic ac);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.mode  = m;
    u.dest  = d;
    u.accum = ac;
    u.last  = 1'b0;
    return u;
  endfunction

  function automatic uop_t get_uop(input logic [1:0] prog, input logic [4:0] pc,
                                   input logic [1:0] rz, input logic [1:0] ry);
    uop_t u;
    u = mk(S_ONE, S_ONE, MODE_ROUND, D_NONE, 1'b0);
    unique case (prog)
      KIND_UNIFORM: begin
        unique case (pc)
          5'd0:  u = mk(S_CY, S_F, MODE_ROUND, D_WY, 1'b0);
          5'd1:  u = mk(S_CZ, S_F, MODE_ROUND, D_WZ, 1'b0);
          5'd2:  u = mk(S_CA, S_F, MODE_ROUND, D_WA, 1'b0);
          5'd3:  u = mk(S_WY, S_L, MODE_ROUND, D_LY, 1'b0);
          5'd4:  u = mk(S_WZ, S_L, MODE_ROUND, D_LZ, 1'b0);
          5'd5:  u = mk(S_WA, S_L, MODE_ROUND, D_P, 1'b0);
          5'd6:  u = mk(S_P, S_ONE, MODE_ROUND, D_RA0, 1'b0);
          5'd7:  u = mk(S_P, S_HALF, MODE_ROUND, D_FE0, 1'b0);
          5'd8:  u = mk(S_LY, S_HALF, MODE_ROUND, D_RA1, 1'b0);
          5'd9:  u = mk(S_LY, S_HALF, MODE_ROUND, D_RA2, 1'b0);
          5'd10: u = mk(S_LZ, S_HALF, MODE_ROUND, D_RA3, 1'b0);
          5'd11: u = mk(S_LZ, S_HALF, MODE_ROUND, D_RA4, 1'b0);
          5'd12: u = mk(S_LY, S_L, MODE_ROUND, D_TY, 1'b0);
          5'd13: u = mk(S_LZ, S_L, MODE_ROUND, D_TZ, 1'b0);
          5'd14: u = mk(S_TY, S_ONE, MODE_DIV12, D_KI, 1'b0);
          5'd15: u = mk(S_TZ, S_ONE, MODE_DIV12, D_KJ, 1'b0);
          5'd16: begin
            if (rz == REL_NONE) u = mk(S_KI, S_ONE, MODE_ROUND, D_FE1, 1'b0);
            else if (rz == REL_J) u = mk(S_TY, S_EIGHTH, MODE_ROUND, D_FE1, 1'b0);
          end
          5'd17: begin
            if (rz == REL_NONE) u = mk(S_KI, S_ONE, MODE_ROUND, D_FE2, 1'b0);
            else if (rz == REL_I) u = mk(S_TY, S_EIGHTH, MODE_ROUND, D_FE2, 1'b0);
          end
          5'd18: begin
            if (ry == REL_NONE) u = mk(S_KJ, S_ONE, MODE_ROUND, D_FE3, 1'b0);
            else if (ry == REL_J) u = mk(S_TZ, S_EIGHTH, MODE_ROUND, D_FE3, 1'b0);
          end
          5'd19: begin
            if (ry == REL_NONE) u = mk(S_KJ, S_ONE, MODE_ROUND, D_FE4, 1'b0);
            else if (ry == REL_I) u = mk(S_TZ, S_EIGHTH, MODE_ROUND, D_FE4, 1'b0);
          end
          default: ;
        endcase
        u.last = (pc == 5'd19);
      end
      KIND_PARTIAL: begin
        unique case (pc)
          5'd0:  u = mk(S_CY, S_F, MODE_ROUND, D_WY, 1'b0);
          5'd1:  u = mk(S_CZ, S_F, MODE_ROUND, D_WZ, 1'b0);
          5'd2:  u = mk(S_CA, S_F, MODE_ROUND, D_WA, 1'b0);
          5'd3:  u = mk(S_L, S_G, MODE_ROUND, D_LG, 1'b0);
          5'd4:  u = mk(S_WA, S_LG, MODE_ROUND, D_P, 1'b0);
          5'd5:  u = mk(S_P, S_ONE, MODE_ROUND, D_RA0, 1'b0);
          5'd6:  u = mk(S_P, S_C, MODE_ROUND, D_FE0, 1'b0);
          5'd7:  u = mk(S_WY, S_LG, MODE_ROUND, D_SY, 1'b0);
          5'd8:  u = mk(S_WZ, S_LG, MODE_ROUND, D_SZ, 1'b0);
          5'd9:  u = mk(S_SY, S_OC, MODE_ROUND, D_RA1, 1'b0);
          5'd10: u = mk(S_SY, S_C, MODE_ROUND, D_RA2, 1'b0);
          5'd11: u = mk(S_SZ, S_OC, MODE_ROUND, D_RA3, 1'b0);
          5'd12: u = mk(S_SZ, S_C, MODE_ROUND, D_RA4, 1'b0);
          5'd13: u = mk(S_G, S_G, MODE_ROUND, D_G2, 1'b0);
          5'd14: u = mk(S_OC, S_OC, MODE_ROUND, D_T, 1'b0);
          5'd15: u = mk(S_C, S_T, MODE_ROUND, D_KI, 1'b0);
          5'd16: u = mk(S_G2, S_K3A, MODE_ROUND, D_T, 1'b0);
          5'd17: u = mk(S_T, S_ONE, MODE_DIV12, D_KI, 1'b1);
          5'd18: u = mk(S_C, S_C, MODE_ROUND, D_T, 1'b0);
          5'd19: u = mk(S_OC, S_T, MODE_ROUND, D_KJ, 1'b0);
          5'd20: u = mk(S_G2, S_K3B, MODE_ROUND, D_T, 1'b0);
          5'd21: u = mk(S_T, S_ONE, MODE_DIV12, D_KJ, 1'b1);
          5'd22: u = mk(S_G, S_KI, MODE_ROUND, D_KI, 1'b0);
          5'd23: u = mk(S_G, S_KJ, MODE_ROUND, D_KJ, 1'b0);
          5'd24: u = mk(S_WY, S_L, MODE_ROUND, D_LY, 1'b0);
          5'd25: u = mk(S_LY, S_L, MODE_ROUND, D_TY, 1'b0);
          5'd26: u = mk(S_WZ, S_L, MODE_ROUND, D_LZ, 1'b0);
          5'd27: u = mk(S_LZ, S_L, MODE_ROUND, D_TZ, 1'b0);
          5'd28: u = mk(S_TY, S_KI, MODE_ROUND, D_FE1, 1'b0);
          5'd29: u = mk(S_TY, S_KJ, MODE_ROUND, D_FE2, 1'b0);
          5'd30: u = mk(S_TZ, S_KI, MODE_ROUND, D_FE3, 1'b0);
          5'd31: u = mk(S_TZ, S_KJ, MODE_ROUND, D_FE4, 1'b0);
          default: ;
        endcase
        u.last = (pc == 5'd31);
      end
      KIND_POINT: begin
        unique case (pc)
          5'd0:  u = mk(S_CY, S_F, MODE_ROUND, D_WY, 1'b0);
          5'd1:  u = mk(S_CZ, S_F, MODE_ROUND, D_WZ, 1'b0);
          5'd2:  u = mk(S_CA, S_F, MODE_ROUND, D_WA, 1'b0);
          5'd3:  u = mk(S_WA, S_ONE, MODE_ROUND, D_RA0, 1'b0);
          5'd4:  u = mk(S_WA, S_C, MODE_ROUND, D_FE0, 1'b0);
          5'd5:  u = mk(S_WY, S_OC, MODE_ROUND, D_RA1, 1'b0);
          5'd6:  u = mk(S_WY, S_C, MODE_ROUND, D_RA2, 1'b0);
          5'd7:  u = mk(S_WZ, S_OC, MODE_ROUND, D_RA3, 1'b0);
          5'd8:  u = mk(S_WZ, S_C, MODE_ROUND, D_RA4, 1'b0);
          5'd9:  u = mk(S_OC, S_OC, MODE_ROUND, D_T, 1'b0);
          5'd10: u = mk(S_C, S_T, MODE_ROUND, D_KI, 1'b0);
          5'd11: u = mk(S_C, S_C, MODE_ROUND, D_T, 1'b0);
          5'd12: u = mk(S_T, S_OC, MODE_ROUND, D_KJ, 1'b0);
          5'd13: u = mk(S_WY, S_L, MODE_ROUND, D_LY, 1'b0);
          5'd14: u = mk(S_WZ, S_L, MODE_ROUND, D_LZ, 1'b0);
          5'd15: u = mk(S_LY, S_KI, MODE_ROUND, D_FE1, 1'b0);
          5'd16: u = mk(S_LY, S_KJ, MODE_ROUND, D_FE2, 1'b0);
          5'd17: u = mk(S_LZ, S_KI, MODE_ROUND, D_FE3, 1'b0);
          5'd18: u = mk(S_LZ, S_KJ, MODE_ROUND, D_FE4, 1'b0);
          default: ;
        endcase
        u.last = (pc == 5'd18);
      end
      default: u.last = 1'b1;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### design/bfela_datapath.sv
// datapath: input capture, config registers, shared multiplier,
// temporaries, saturating accumulators and output registers; uses bfela_pkg
`timescale 1ns / 1ps
`default_nettype none

module bfela_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [30:0]         cfg_wr_data,
  input  logic                operation,
  input  logic [1:0]          load_kind,
  input  logic signed [31:0]  comp_y,
  input  logic signed [31:0]  comp_z,
  input  logic signed [31:0]  comp_axial,
  input  logic signed [17:0]  start_frac,
  input  logic [16:0]         end_frac,
  input  logic signed [31:0]  load_factor,
  input  bfela_pkg::cmd_t     cmd,
  output bfela_pkg::stat_t    stat,
  output logic [1:0]          status,
  output logic signed [31:0]  react_axial,
  output logic signed [31:0]  react_shear_y_i,
  output logic signed [31:0]  react_shear_y_j,
  output logic signed [31:0]  react_shear_z_i,
  output logic signed [31:0]  react_shear_z_j,
  output logic signed [31:0]  fixed_axial,
  output logic signed [31:0]  fixed_moment_z_i,
  output logic signed [31:0]  fixed_moment_z_j,
  output logic signed [31:0]  fixed_moment_y_i,
  output logic signed [31:0]  fixed_moment_y_j
);
  import bfela_pkg::*;

  // config
  logic [30:0] beam_length;
  logic [1:0]  rel_z;
  logic [1:0]  rel_y;

  // captured item
  logic              op_r;
  logic [1:0]        kind_r;
  logic              oor_r;
  logic signed [DW-1:0] cy, cz, ca, fct;
  logic signed [PW-1:0] g_r, c_r, oc_r, k3a_r, k3b_r;

  // temporaries
  logic signed [DW-1:0] wy, wz, wa, lg, p, sy, sz, g2, t, ki, kj, ly, lz, ty, tz;

  logic signed [DW-1:0] acc [NUM_ACC];
  logic signed [DW-1:0] acc_out [NUM_ACC];
  logic [1:0]           status_r;

  // position terms at capture
  logic signed [PW-1:0] fs_x, fe_x, psum, c_next, oc_next;

  always_comb begin
    fs_x    = PW'(start_frac);
    fe_x    = PW'(signed'({1'b0, end_frac}));
    psum    = fs_x + fe_x + PW'(1);
    c_next  = (load_kind == KIND_POINT) ? fs_x : (psum >>> 1);
    oc_next = PW'(Q_ONE) - c_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_length <= 31'(Q_ONE);
      rel_z       <= REL_NONE;
      rel_y       <= REL_NONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_LENGTH: beam_length <= cfg_wr_data;
        CFG_REL_Z:  rel_z <= cfg_wr_data[1:0];
        CFG_REL_Y:  rel_y <= cfg_wr_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= operation;
      kind_r <= load_kind;
      oor_r  <= start_frac[17] || (fs_x > PW'(Q_ONE));
      cy     <= comp_y;
      cz     <= comp_z;
      ca     <= comp_axial;
      fct    <= load_factor;
      g_r    <= fe_x - fs_x;
      c_r    <= c_next;
      oc_r   <= oc_next;
      k3a_r  <= c_next + c_next + c_next - PW'(Q_ONE) - PW'(Q_ONE);
      k3b_r  <= PW'(Q_ONE) - c_next - c_next - c_next;
    end
  end

  assign stat.op        = op_r;
  assign stat.kind      = kind_r;
  assign stat.point_oor = oor_r;
  assign stat.rz        = rel_z;
  assign stat.ry        = rel_y;

  // operand select
  logic signed [DW-1:0] src [NUM_SRC];

  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) src[i] = '0;
    src[S_CY]     = cy;
    src[S_CZ]     = cz;
    src[S_CA]     = ca;
    src[S_F]      = fct;
    src[S_L]      = signed'({1'b0, beam_length});
    src[S_G]      = DW'(g_r);
    src[S_C]      = DW'(c_r);
    src[S_OC]     = DW'(oc_r);
    src[S_K3A]    = DW'(k3a_r);
    src[S_K3B]    = DW'(k3b_r);
    src[S_ONE]    = Q_ONE;
    src[S_HALF]   = Q_HALF;
    src[S_EIGHTH] = Q_EIGHTH;
    src[S_WY]     = wy;
    src[S_WZ]     = wz;
    src[S_WA]     = wa;
    src[S_LG]     = lg;
    src[S_P]      = p;
    src[S_SY]     = sy;
    src[S_SZ]     = sz;
    src[S_G2]     = g2;
    src[S_T]      = t;
    src[S_KI]     = ki;
    src[S_KJ]     = kj;
    src[S_LY]     = ly;
    src[S_LZ]     = lz;
    src[S_TY]     = ty;
    src[S_TZ]     = tz;
  end

  logic signed [DW-1:0] a_v, b_v, ma, mb, dx;
  logic signed [DW:0]   dsum;
  logic                 dneg;

  // divide by 12 as floor((v + 6) / 4) / 3, odd-symmetric fold for negatives
  always_comb begin
    a_v  = src[cmd.uop.a_sel];
    b_v  = src[cmd.uop.b_sel];
    dsum = (DW + 1)'(a_v) + (DW + 1)'(6);
    dx   = DW'(dsum >>> 2);
    dneg = dx[DW-1];
    if (cmd.uop.mode == MODE_DIV12) begin
      ma = dneg ? ~dx : dx;
      mb = DIV3_MAGIC;
    end else begin
      ma = a_v;
      mb = b_v;
    end
  end

  logic signed [2*DW-1:0] prod;
  logic                   mode_q, neg_q, accum_q;
  logic [4:0]             dest_q;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod    <= (2*DW)'(ma) * (2*DW)'(mb);
      mode_q  <= cmd.uop.mode;
      neg_q   <= dneg;
      accum_q <= cmd.uop.accum;
      dest_q  <= cmd.uop.dest;
    end
  end

  logic signed [2*DW-1:0] rnd;
  logic signed [DW-1:0]   res_round, res_div, res, q_hi;

  always_comb begin
    rnd = (prod + ((2*DW)'(1) <<< (SHIFT - 1))) >>> SHIFT;
    if (rnd > (2*DW)'(32'sh7fffffff))       res_round = 32'sh7fffffff;
    else if (rnd < -(2*DW)'(33'sh80000000)) res_round = 32'sh80000000;
    else                                    res_round = DW'(rnd);
    q_hi    = prod[2*DW-1:DW];
    res_div = neg_q ? ~q_hi : q_hi;
    res     = (mode_q == MODE_DIV12) ? res_div : res_round;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      unique case (dest_q)
        D_WY: wy <= res;
        D_WZ: wz <= res;
        D_WA: wa <= res;
        D_LG: lg <= res;
        D_P:  p  <= res;
        D_SY: sy <= res;
        D_SZ: sz <= res;
        D_G2: g2 <= res;
        D_T:  t  <= res;
        D_KI: ki <= accum_q ? ki + res : res;
        D_KJ: kj <= accum_q ? kj + res : res;
        D_LY: ly <= res;
        D_LZ: lz <= res;
        D_TY: ty <= res;
        D_TZ: tz <= res;
        default: ;
      endcase
    end
  end

  // accumulators: fixed direction each, saturating
  logic signed [DW:0] acc_sum [NUM_ACC];

  always_comb begin
    for (int k = 0; k < NUM_ACC; k++) begin
      if ((5'(k) + D_RA0 == D_FE2) || (5'(k) + D_RA0 == D_FE3))
        acc_sum[k] = (DW + 1)'(acc[k]) + (DW + 1)'(res);
      else
        acc_sum[k] = (DW + 1)'(acc[k]) - (DW + 1)'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_acc) begin
      for (int k = 0; k < NUM_ACC; k++) acc[k] <= '0;
    end else if (cmd.wr) begin
      for (int k = 0; k < NUM_ACC; k++) begin
        if (dest_q == 5'(k) + D_RA0) begin
          if (acc_sum[k][DW] != acc_sum[k][DW-1])
            acc[k] <= acc_sum[k][DW] ? 32'sh80000000 : 32'sh7fffffff;
          else
            acc[k] <= DW'(acc_sum[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) status_r <= cmd.status_code;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= status_r;
      for (int k = 0; k < NUM_ACC; k++) acc_out[k] <= acc[k];
    end
  end

  assign react_axial      = acc_out[0];
  assign react_shear_y_i  = acc_out[1];
  assign react_shear_y_j  = acc_out[2];
  assign react_shear_z_i  = acc_out[3];
  assign react_shear_z_j  = acc_out[4];
  assign fixed_axial      = acc_out[5];
  assign fixed_moment_z_i = acc_out[6];
  assign fixed_moment_z_j = acc_out[7];
  assign fixed_moment_y_i = acc_out[8];
  assign fixed_moment_y_j = acc_out[9];

endmodule

`default_nettype wire

### design/bfela_ctrl.sv
// controller: handshake, item decode and micro-op sequencing
// uses bfela_pkg; drives bfela_datapath through cmd_t
`timescale 1ns / 1ps
`default_nettype none

module bfela_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bfela_pkg::stat_t stat,
  output bfela_pkg::cmd_t  cmd
);
  import bfela_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state, state_next;
  logic [4:0] pc, pc_next;
  logic       phase, phase_next;
  logic [1:0] prog, prog_next;
  logic       out_valid_next;
  uop_t       uop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      phase     <= 1'b0;
      prog      <= KIND_UNIFORM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      phase     <= phase_next;
      prog      <= prog_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    phase_next = phase;
    prog_next  = prog;
    uop        = get_uop(prog, pc, stat.rz, stat.ry);
    cmd        = '0;
    cmd.uop    = uop;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        priority if (!stat.op) begin
          cmd.clear_acc   = 1'b1;
          cmd.status_code = ST_APPLIED;
          state_next      = S_DONE;
        end else if (stat.kind == KIND_UNKNOWN) begin
          cmd.status_code = ST_UNKNOWN;
          state_next      = S_DONE;
        end else if (stat.kind == KIND_POINT && stat.point_oor) begin
          cmd.status_code = ST_IGNORED;
          state_next      = S_DONE;
        end else begin
          cmd.status_code = ST_APPLIED;
          prog_next       = stat.kind;
          pc_next         = '0;
          phase_next      = 1'b0;
          state_next      = S_RUN;
        end
      end
      S_RUN: begin
        // issue a product, then write it back the next cycle
        if (!phase) begin
          cmd.issue  = 1'b1;
          phase_next = 1'b1;
        end else begin
          cmd.wr     = 1'b1;
          phase_next = 1'b0;
          if (uop.last) state_next = S_DONE;
          else          pc_next = pc + 5'd1;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

endmodule

`default_nettype wire

### design/beam_fixed_end_load_accumulator.sv
// Fixed-end load accumulator for a 3D beam element with moment releases.
// Input channel (in_valid/in_ready): one item is a clear or one load
// (uniform, partial uniform or point). Output channel (out_valid/out_ready):
// one result per item, the status and all ten accumulators after the item.
// Config port: cfg_wr_en writes cfg_wr_data to register cfg_addr
// (0 length, 1 release about z, 2 release about y); the user must write
// only while idle, the block itself does not enforce this. Every product
// goes through the one shared 32x32 multiplier, first issued, then rounded
// and written back; the sequencer runs 19 such steps for a point load, 20
// for a uniform load, 32 for a partial load and none for a clear, an
// unknown kind or an ignored point. The next item is taken the cycle after
// the result is loaded into the output register, so a result waiting on a
// stalled receiver does not block the next item; a second finished result
// waits until the first is transferred. Reset clears the accumulators,
// sets the length to 1.0 and the releases to none, and empties the output
// register.
`timescale 1ns / 1ps
`default_nettype none
`include "beam_fixed_end_load_accumulator_defines.svh"

module beam_fixed_end_load_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_addr,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [1:0]         load_kind,
  input  logic signed [31:0] comp_y,
  input  logic signed [31:0] comp_z,
  input  logic signed [31:0] comp_axial,
  input  logic signed [17:0] start_frac,
  input  logic [16:0]        end_frac,
  input  logic signed [31:0] load_factor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] react_axial,
  output logic signed [31:0] react_shear_y_i,
  output logic signed [31:0] react_shear_y_j,
  output logic signed [31:0] react_shear_z_i,
  output logic signed [31:0] react_shear_z_j,
  output logic signed [31:0] fixed_axial,
  output logic signed [31:0] fixed_moment_z_i,
  output logic signed [31:0] fixed_moment_z_j,
  output logic signed [31:0] fixed_moment_y_i,
  output logic signed [31:0] fixed_moment_y_j
);
  import bfela_pkg::*;

  cmd_t  ctrl_cmd;
  stat_t dp_stat;

  bfela_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  bfela_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wr_data      (cfg_wr_data),
    .operation        (operation),
    .load_kind        (load_kind),
    .comp_y           (comp_y),
    .comp_z           (comp_z),
    .comp_axial       (comp_axial),
    .start_frac       (start_frac),
    .end_frac         (end_frac),
    .load_factor      (load_factor),
    .cmd              (ctrl_cmd),
    .stat             (dp_stat),
    .status           (status),
    .react_axial      (react_axial),
    .react_shear_y_i  (react_shear_y_i),
    .react_shear_y_j  (react_shear_y_j),
    .react_shear_z_i  (react_shear_z_i),
    .react_shear_z_j  (react_shear_z_j),
    .fixed_axial      (fixed_axial),
    .fixed_moment_z_i (fixed_moment_z_i),
    .fixed_moment_z_j (fixed_moment_z_j),
    .fixed_moment_y_i (fixed_moment_y_i),
    .fixed_moment_y_j (fixed_moment_y_j)
  );

  `BFELA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `BFELA_ASSERT_NOW(a_no_step_when_idle, ctrl_cmd.issue || ctrl_cmd.wr, !in_ready, "step while idle")
  `BFELA_ASSERT_NOW(a_load_out_free, ctrl_cmd.load_out, !out_valid || out_ready, "result overwritten")
  `BFELA_ASSERT_RST(a_reset_state, rst, !out_valid && in_ready, "bad state after reset")

endmodule

`default_nettype wire
